// ===== rtl/ghh_pkg.sv =====
// Shared constants, codes and a helper function for the gyro heading hold block.
// Used by ghh_div, ghh_mul, gyro_heading_hold and the testbench.
package ghh_pkg;

  localparam int MAX_CAL_SAMPLES = 4096;

  localparam int RATE_W = 16;
  localparam int STEP_W = 16;
  localparam int HEAD_W = 48;
  localparam int THR_W  = 47;
  localparam int BYTE_W = 8;
  localparam int FRAC_W = 26;
  localparam int CFG_W  = 47;
  localparam int IDX_W  = 3;

  localparam int CNT_W  = $clog2(MAX_CAL_SAMPLES + 1);
  localparam int SUM_W  = RATE_W + CNT_W + 1;
  localparam int ITER_W = $clog2(SUM_W);
  localparam int DIFF_W = RATE_W + 1;
  localparam int MUL_AW = HEAD_W;
  localparam int MUL_BW = STEP_W + 1;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int MOT_W  = HEAD_W + BYTE_W + 2;

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_INTEGRATE = 2'd1,
    CMD_CALIBRATE = 2'd2,
    CMD_RESET     = 2'd3
  } cmd_t;

  localparam logic [IDX_W-1:0] REG_DEADBAND = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_POS = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_NEG = 3'd2;
  localparam logic [IDX_W-1:0] REG_BASE_POS = 3'd3;
  localparam logic [IDX_W-1:0] REG_BASE_NEG = 3'd4;

  localparam logic [THR_W-1:0]  DEADBAND_RST = 47'd5856284;
  localparam logic [BYTE_W-1:0] GAIN_POS_RST = 8'd15;
  localparam logic [BYTE_W-1:0] GAIN_NEG_RST = 8'd20;
  localparam logic [BYTE_W-1:0] BASE_POS_RST = 8'd128;
  localparam logic [BYTE_W-1:0] BASE_NEG_RST = 8'd129;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [BYTE_W-1:0] speed_byte(input logic [MOT_W-1:0] v);
    logic [BYTE_W-1:0] r;
    if (v[MOT_W-1] || (v == '0)) begin
      r = '0;
    end else if (|v[MOT_W-1:FRAC_W+BYTE_W]) begin
      r = '1;
    end else begin
      r = v[FRAC_W+BYTE_W-1:FRAC_W];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ghh_in_if.sv =====
// Input channel of the gyro heading hold block: command, rate sample and time step.
// Standalone; no package dependency.
interface ghh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic signed [15:0] gyro_rate;
  logic [15:0] time_step;

  modport source (output valid, command, gyro_rate, time_step, input ready);
  modport sink (input valid, command, gyro_rate, time_step, output ready);
endinterface

// ===== rtl/ghh_out_if.sv =====
// Result channel of the gyro heading hold block: heading, mode and motor bytes.
// Standalone; no package dependency.
interface ghh_out_if;
  logic        valid;
  logic        ready;
  logic signed [47:0] yaw_angle;
  logic        integrating;
  logic        motor_valid;
  logic [7:0]  left_speed;
  logic [7:0]  right_speed;

  modport source (output valid, yaw_angle, integrating, motor_valid, left_speed,
                  right_speed, input ready);
  modport sink (input valid, yaw_angle, integrating, motor_valid, left_speed,
                right_speed, output ready);
endinterface

// ===== rtl/gyro_heading_hold.sv =====
// Gyro heading hold: bias calibration, yaw integration and proportional motor bytes.
// Top level; uses ghh_pkg, ghh_in_if, ghh_out_if, ghh_div and ghh_mul.
//
// Usage:
//   samples carries one item per sample or command (command, gyro_rate, time_step).
//   results carries exactly one item per input item: heading, mode, motor pair.
//   cfg_write/cfg_index/cfg_data write a register at the clock edge; no read-back.
// Timing:
//   One item is worked at a time; samples.ready is high only while the sequencer
//   is idle. A result is written to the output register from S_DONE, its path
//   paced by the shared multiplier used twice and the single adder used for both
//   motor bytes.
//   Command 1 with collected samples also runs the bit-serial divider.
// Reset:
//   rst clears heading, bias, samples and mode, and loads register defaults.
// Stall:
//   A finished result waits in the output register; the next item is taken
//   meanwhile, and its result waits until results.ready frees the register.
module gyro_heading_hold (
  input  logic                      clk,
  input  logic                      rst,
  ghh_in_if.sink                    samples,
  ghh_out_if.source                 results,
  input  logic                      cfg_write,
  input  logic [ghh_pkg::IDX_W-1:0] cfg_index,
  input  logic [ghh_pkg::CFG_W-1:0] cfg_data
);
  import ghh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DIV, S_ACC, S_CMP, S_MULG, S_LEFT, S_RIGHT, S_DONE
  } state_t;

  state_t state;

  logic [THR_W-1:0]  deadband;
  logic [BYTE_W-1:0] gain_pos;
  logic [BYTE_W-1:0] gain_neg;
  logic [BYTE_W-1:0] base_pos;
  logic [BYTE_W-1:0] base_neg;

  cmd_t                     cmd;
  logic signed [RATE_W-1:0] rate;
  logic [STEP_W-1:0]        step;
  logic signed [HEAD_W-1:0] heading;
  logic signed [RATE_W-1:0] bias;
  logic signed [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]         count;
  logic                     mode;
  logic                     mv;
  logic                     side_pos;
  logic                     div_neg;
  logic [BYTE_W-1:0]        left;
  logic [BYTE_W-1:0]        right;

  logic                     res_load;
  logic                     res_valid;
  logic signed [HEAD_W-1:0] res_yaw;
  logic                     res_mode;
  logic                     res_mv;
  logic [BYTE_W-1:0]        res_left;
  logic [BYTE_W-1:0]        res_right;

  logic                     mul_en;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p;

  logic                     div_start;
  logic [SUM_W-1:0]         div_dividend;
  div_stat_t                div_stat;
  logic [SUM_W-1:0]         div_q;
  logic [RATE_W-1:0]        q16;

  logic signed [DIFF_W-1:0] rate_diff;
  logic signed [HEAD_W:0]   acc_sum;
  logic signed [HEAD_W-1:0] acc_sat;
  logic signed [HEAD_W-1:0] thr_s;
  logic                     pos_hit;
  logic                     neg_hit;
  logic [BYTE_W-1:0]        gsel;
  logic [BYTE_W-1:0]        bsel;
  logic [MOT_W-1:0]         bq;
  logic [MOT_W-1:0]         mot_p;
  logic [MOT_W-1:0]         mot_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= DEADBAND_RST;
      gain_pos <= GAIN_POS_RST;
      gain_neg <= GAIN_NEG_RST;
      base_pos <= BASE_POS_RST;
      base_neg <= BASE_NEG_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEADBAND: deadband <= cfg_data[THR_W-1:0];
        REG_GAIN_POS: gain_pos <= cfg_data[BYTE_W-1:0];
        REG_GAIN_NEG: gain_neg <= cfg_data[BYTE_W-1:0];
        REG_BASE_POS: base_pos <= cfg_data[BYTE_W-1:0];
        REG_BASE_NEG: base_neg <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rate_diff = {rate[RATE_W-1], rate} - {bias[RATE_W-1], bias};
    gsel      = side_pos ? gain_pos : gain_neg;
    bsel      = side_pos ? base_pos : base_neg;
    mul_en    = (state == S_EXEC) || (state == S_MULG);
    if (state == S_MULG) begin
      mul_a = heading;
      mul_b = MUL_BW'({1'b0, gsel});
    end else begin
      mul_a = MUL_AW'(rate_diff);
      mul_b = {1'b0, step};
    end
  end

  ghh_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign div_start    = (state == S_EXEC) && (cmd == CMD_INTEGRATE) && (count != '0);
  assign div_dividend = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign q16          = div_q[RATE_W-1:0];

  ghh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_comb begin
    acc_sum = {heading[HEAD_W-1], heading} + mul_p[HEAD_W:0];
    if (acc_sum[HEAD_W] != acc_sum[HEAD_W-1]) begin
      acc_sat = acc_sum[HEAD_W] ? {1'b1, {(HEAD_W-1){1'b0}}} : {1'b0, {(HEAD_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[HEAD_W-1:0];
    end
    thr_s   = {1'b0, deadband};
    pos_hit = heading > thr_s;
    neg_hit = heading < -thr_s;
    bq      = MOT_W'({bsel, {FRAC_W{1'b0}}});
    mot_p   = mul_p[MOT_W-1:0];
    mot_v   = (state == S_LEFT) ? (bq + mot_p) : (bq - mot_p);
  end

  assign res_load = (state == S_DONE) && (!res_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
      res_yaw   <= heading;
      res_mode  <= mode;
      res_mv    <= mv;
      res_left  <= left;
      res_right <= right;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= 1'b0;
      heading   <= '0;
      bias      <= '0;
      sum       <= '0;
      count     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (samples.valid) begin
            cmd   <= cmd_t'(samples.command);
            rate  <= samples.gyro_rate;
            step  <= samples.time_step;
            mv    <= 1'b0;
            left  <= '0;
            right <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd)
            CMD_INTEGRATE: begin
              mode    <= 1'b1;
              sum     <= '0;
              count   <= '0;
              div_neg <= sum[SUM_W-1];
              if (count == '0) begin
                bias  <= '0;
                state <= S_DONE;
              end else begin
                state <= S_DIV;
              end
            end
            CMD_CALIBRATE: begin
              mode  <= 1'b0;
              sum   <= '0;
              count <= '0;
              state <= S_DONE;
            end
            CMD_RESET: begin
              mode    <= 1'b0;
              heading <= '0;
              bias    <= '0;
              sum     <= '0;
              count   <= '0;
              state   <= S_DONE;
            end
            default: begin
              if (step == '0) begin
                state <= S_DONE;
              end else if (!mode) begin
                if (count < CNT_W'(MAX_CAL_SAMPLES)) begin
                  sum   <= sum + SUM_W'(rate);
                  count <= count + 1'b1;
                end
                state <= S_CMP;
              end else begin
                state <= S_ACC;
              end
            end
          endcase
        end
        S_DIV: begin
          if (div_stat.done) begin
            bias  <= div_neg ? -q16 : q16;
            state <= S_DONE;
          end
        end
        S_ACC: begin
          heading <= acc_sat;
          state   <= S_CMP;
        end
        S_CMP: begin
          if (pos_hit) begin
            mv       <= 1'b1;
            side_pos <= 1'b1;
            state    <= S_MULG;
          end else if (neg_hit) begin
            mv       <= 1'b1;
            side_pos <= 1'b0;
            state    <= S_MULG;
          end else begin
            state <= S_DONE;
          end
        end
        S_MULG: begin
          state <= S_LEFT;
        end
        S_LEFT: begin
          left  <= speed_byte(mot_v);
          state <= S_RIGHT;
        end
        S_RIGHT: begin
          right <= speed_byte(mot_v);
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign samples.ready       = (state == S_IDLE);
  assign results.valid       = res_valid;
  assign results.yaw_angle   = res_yaw;
  assign results.integrating = res_mode;
  assign results.motor_valid = res_mv;
  assign results.left_speed  = res_left;
  assign results.right_speed = res_right;

  a_idle_speeds: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.motor_valid |-> results.left_speed == '0 &&
      results.right_speed == '0)
    else $error("speed bytes nonzero without a motor pair");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_CAL_SAMPLES))
    else $error("calibration count beyond bound");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> state == S_EXEC)
    else $error("accepted item not dispatched");

  a_div_finish: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && div_stat.done |=> state == S_DONE)
    else $error("divider result not taken");
endmodule

// ===== rtl/ghh_div.sv =====
// Restoring divider, one quotient bit per cycle, for the calibration mean.
// Depends on ghh_pkg.
module ghh_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ghh_pkg::SUM_W-1:0] dividend,
  input  logic [ghh_pkg::CNT_W-1:0] divisor,
  output ghh_pkg::div_stat_t        stat,
  output logic [ghh_pkg::SUM_W-1:0] quotient
);
  import ghh_pkg::*;

  logic [SUM_W-1:0]  quot;
  logic [CNT_W:0]    rem;
  logic [CNT_W-1:0]  dvs;
  logic [ITER_W-1:0] iter;
  logic              busy;
  logic              done;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              ge;

  always_comb begin
    rem_sh = {rem[CNT_W-1:0], quot[SUM_W-1]};
    ge     = rem_sh >= {1'b0, dvs};
    diff   = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= ITER_W'(SUM_W - 1);
      end else if (busy) begin
        if (iter == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          iter <= iter - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[SUM_W-2:0], ge};
      rem  <= ge ? diff : rem_sh;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quot;
endmodule

// ===== rtl/ghh_mul.sv =====
// Shared signed multiplier with registered product.
// Serves the rate-times-step and the gain-times-heading products. Depends on ghh_pkg.
module ghh_mul (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ghh_pkg::MUL_AW-1:0] a,
  input  logic signed [ghh_pkg::MUL_BW-1:0] b,
  output logic signed [ghh_pkg::MUL_PW-1:0] p
);
  import ghh_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= MUL_PW'(a * b);
    end
  end
endmodule

// ===== verif/gyro_heading_hold_tb.sv =====
// Testbench for gyro_heading_hold: drives samples and commands, writes registers between
// phases and checks every result item against a predictor kept in a scoreboard class.
// Depends on ghh_pkg, ghh_in_if, ghh_out_if and the gyro_heading_hold RTL.
`timescale 1ns / 1ps

module gyro_heading_hold_tb;
  import ghh_pkg::*;

  localparam longint YAW_MAX = (longint'(1) <<< 47) - 1;
  localparam longint YAW_MIN = -YAW_MAX - 1;
  localparam logic signed [15:0] RATE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] RATE_MIN = 16'sh8000;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic signed [47:0] yaw;
    logic               integrating;
    logic               motor_valid;
    logic [7:0]         left;
    logic [7:0]         right;
  } yaw_result_t;

  class heading_tracker;
    logic [THR_W-1:0]  deadband;
    logic [BYTE_W-1:0] gain_pos, gain_neg, base_pos, base_neg;
    bit                integrate_mode;
    longint            heading, bias, cal_sum, cal_count;
    yaw_result_t       pending_results[$];
    int                mismatches;

    function void restart();
      deadband = DEADBAND_RST;
      gain_pos = GAIN_POS_RST;
      gain_neg = GAIN_NEG_RST;
      base_pos = BASE_POS_RST;
      base_neg = BASE_NEG_RST;
      integrate_mode = 0;
      heading = 0;
      bias = 0;
      cal_sum = 0;
      cal_count = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_DEADBAND: deadband = data[THR_W-1:0];
        REG_GAIN_POS: gain_pos = data[BYTE_W-1:0];
        REG_GAIN_NEG: gain_neg = data[BYTE_W-1:0];
        REG_BASE_POS: base_pos = data[BYTE_W-1:0];
        REG_BASE_NEG: base_neg = data[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] motor_byte(longint v);
      longint q;
      if (v <= 0) return 8'd0;
      q = v >>> FRAC_W;
      if (q > 255) return 8'd255;
      return q[7:0];
    endfunction

    function void predict_item(cmd_t c, logic signed [15:0] rate_in, logic [15:0] step_in);
      yaw_result_t exp_r;
      longint rate, step, h, thr, g, b;
      bit issue;
      rate = rate_in;
      step = step_in;
      issue = 0;
      g = 0;
      b = 0;
      case (c)
        CMD_INTEGRATE: begin
          integrate_mode = 1;
          bias = (cal_count == 0) ? 0 : cal_sum / cal_count;
          cal_sum = 0;
          cal_count = 0;
        end
        CMD_CALIBRATE: begin
          integrate_mode = 0;
          cal_sum = 0;
          cal_count = 0;
        end
        CMD_RESET: begin
          integrate_mode = 0;
          heading = 0;
          bias = 0;
          cal_sum = 0;
          cal_count = 0;
        end
        CMD_SAMPLE: begin
          if (step != 0) begin
            if (!integrate_mode) begin
              if (cal_count < MAX_CAL_SAMPLES) begin
                cal_sum += rate;
                cal_count++;
              end
            end else begin
              h = heading + (rate - bias) * step;
              if (h > YAW_MAX) h = YAW_MAX;
              if (h < YAW_MIN) h = YAW_MIN;
              heading = h;
            end
            thr = deadband;
            if (heading > thr) begin
              g = gain_pos;
              b = base_pos;
              issue = 1;
            end else if (heading < -thr) begin
              g = gain_neg;
              b = base_neg;
              issue = 1;
            end
          end
        end
        default: ;
      endcase
      exp_r.yaw = heading[47:0];
      exp_r.integrating = integrate_mode;
      exp_r.motor_valid = issue;
      exp_r.left = issue ? motor_byte((b <<< FRAC_W) + g * heading) : 8'd0;
      exp_r.right = issue ? motor_byte((b <<< FRAC_W) - g * heading) : 8'd0;
      pending_results = {pending_results, exp_r};
    endfunction

    function void compare_result(yaw_result_t got);
      yaw_result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: yaw_angle %0d", got.yaw);
        mismatches++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.yaw !== exp_r.yaw) begin
        $error("yaw_angle: expected %0d, got %0d", exp_r.yaw, got.yaw);
        mismatches++;
      end
      if (got.integrating !== exp_r.integrating) begin
        $error("integrating: expected %0d, got %0d", exp_r.integrating, got.integrating);
        mismatches++;
      end
      if (got.motor_valid !== exp_r.motor_valid) begin
        $error("motor_valid: expected %0d, got %0d", exp_r.motor_valid, got.motor_valid);
        mismatches++;
      end
      if (got.left !== exp_r.left) begin
        $error("left_speed: expected %0d, got %0d", exp_r.left, got.left);
        mismatches++;
      end
      if (got.right !== exp_r.right) begin
        $error("right_speed: expected %0d, got %0d", exp_r.right, got.right);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  bit                quiet;
  int                sink_hold;
  int                idle_cycles;
  yaw_result_t       seen;
  heading_tracker    tracker;

  ghh_in_if  samples_if();
  ghh_out_if results_if();

  gyro_heading_hold dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .results   (results_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'd0;
    if (r < 20) return 16'($urandom_range(1, 255));
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic logic signed [15:0] clamp_rate(input int v);
    if (v > 32767) return RATE_MAX;
    if (v < -32768) return RATE_MIN;
    return 16'(v);
  endfunction

  task automatic send_item(input cmd_t c, input logic signed [15:0] rate,
                           input logic [15:0] step);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid     <= 1'b1;
    samples_if.command   <= c;
    samples_if.gyro_rate <= rate;
    samples_if.time_step <= step;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    tracker.predict_item(c, rate, step);
  endtask

  task automatic drain();
    samples_if.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] gp,
                            input logic [CFG_W-1:0] gn, input logic [CFG_W-1:0] bp,
                            input logic [CFG_W-1:0] bn);
    put_reg(REG_DEADBAND, thr);
    put_reg(REG_GAIN_POS, gp);
    put_reg(REG_GAIN_NEG, gn);
    put_reg(REG_BASE_POS, bp);
    put_reg(REG_BASE_NEG, bn);
    if ($urandom_range(0, 2) == 0) put_reg(REG_UNUSED, CFG_W'({$urandom, $urandom}));
    cfg_write <= 1'b0;
  endtask

  task automatic random_settings();
    logic [CFG_W-1:0] thr;
    thr = CFG_W'({$urandom, $urandom}) >> $urandom_range(12, 46);
    write_regs(thr, CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
               CFG_W'($urandom), CFG_W'($urandom));
  endtask

  // calibrate or reset, enter integrate, then a run of samples around the bias
  task automatic run_sequences(input int target);
    int count, center, spread;
    count = 0;
    while (count < target) begin
      quiet = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 3) == 0)
        send_item(CMD_RESET, 16'($urandom), 16'($urandom));
      else
        send_item(CMD_CALIBRATE, 16'($urandom), 16'($urandom));
      center = int'($urandom_range(0, 8000)) - 4000;
      if ($urandom_range(0, 7) == 0) center = int'($urandom_range(0, 65535)) - 32768;
      repeat ($urandom_range(0, 10)) begin
        send_item(CMD_SAMPLE, clamp_rate(center + int'($urandom_range(0, 400)) - 200),
                  pick_step());
        count++;
      end
      send_item(CMD_INTEGRATE, 16'($urandom), 16'($urandom));
      count += 2;
      case ($urandom_range(0, 2))
        0: spread = 300;
        1: spread = 3000;
        default: spread = 32768;
      endcase
      repeat ($urandom_range(4, 40)) begin
        if ($urandom_range(0, 19) == 0)
          send_item(cmd_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
        else
          send_item(CMD_SAMPLE,
                    clamp_rate(center + int'($urandom_range(0, 2 * spread)) - spread),
                    pick_step());
        count++;
      end
    end
    quiet = 0;
  endtask

  initial begin
    results_if.ready = 1'b0;
    sink_hold = 0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        results_if.ready <= 1'b0;
        sink_hold--;
      end else begin
        results_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        seen.yaw         = results_if.yaw_angle;
        seen.integrating = results_if.integrating;
        seen.motor_valid = results_if.motor_valid;
        seen.left        = results_if.left_speed;
        seen.right       = results_if.right_speed;
        tracker.compare_result(seen);
      end
      if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("gyro_heading_hold_tb: done, errors");
    $finish;
  end

  initial begin
    tracker = new();
    tracker.restart();
    quiet = 0;
    rst = 1'b1;
    samples_if.valid = 1'b0;
    samples_if.command = CMD_SAMPLE;
    samples_if.gyro_rate = '0;
    samples_if.time_step = '0;
    cfg_write = 1'b0;
    cfg_index = REG_DEADBAND;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_INTEGRATE, RATE_MAX, 16'hFFFF);
    send_item(CMD_INTEGRATE, RATE_MIN, 16'h0000);
    send_item(CMD_SAMPLE, RATE_MAX, 16'hFFFF);
    send_item(CMD_SAMPLE, 16'sd5, 16'h0001);
    send_item(CMD_SAMPLE, RATE_MIN, 16'hFFFF);
    send_item(CMD_SAMPLE, RATE_MIN, 16'h0800);
    send_item(CMD_SAMPLE, RATE_MAX, 16'h0000);
    send_item(CMD_CALIBRATE, RATE_MAX, 16'hFFFF);
    send_item(CMD_SAMPLE, RATE_MIN, 16'h0001);
    send_item(CMD_SAMPLE, RATE_MAX, 16'h8000);
    send_item(CMD_SAMPLE, -16'sd3, 16'h00FF);
    send_item(CMD_SAMPLE, 16'sd0, 16'h0000);
    send_item(CMD_INTEGRATE, 16'sh5555, 16'hAAAA);
    send_item(CMD_SAMPLE, -16'sd1, 16'd1000);
    send_item(CMD_SAMPLE, 16'sh1234, 16'h0100);
    send_item(CMD_RESET, RATE_MIN, 16'hFFFF);
    send_item(CMD_SAMPLE, RATE_MAX, 16'hFFFF);
    send_item(CMD_INTEGRATE, 16'sd0, 16'h0000);
    send_item(CMD_SAMPLE, RATE_MIN, 16'hFFFF);
    send_item(CMD_RESET, RATE_MAX, 16'h0000);

    drain();
    write_regs('0, CFG_W'(255), CFG_W'(255), CFG_W'(255), '0);
    run_sequences(110);
    drain();
    write_regs('1, '0, '0, '0, '0);
    run_sequences(50);
    repeat (4) begin
      drain();
      random_settings();
      run_sequences(120);
    end

    drain();
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("gyro_heading_hold_tb: done, clean");
    else
      $display("gyro_heading_hold_tb: done, errors");
    $finish;
  end

endmodule
